>>> src/line_counting_receive_fifo_macros.svh
// Assertion macros for the line-counting receive FIFO
`ifndef LINE_COUNTING_RECEIVE_FIFO_MACROS_SVH
`define LINE_COUNTING_RECEIVE_FIFO_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define LCRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCRF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lcrf_pkg.sv
// Package: constants, command codes and index helper for the receive FIFO
`timescale 1ns / 1ps
`default_nettype none

package lcrf_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] LC_MAX = 8'hFF;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_LINE = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef logic [IDX_W-1:0] idx_t;

  function automatic idx_t next_idx(input idx_t i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

endpackage

`default_nettype wire

>>> src/lcrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module lcrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/line_counting_receive_fifo.sv
// A beat accepted goes through stage 1, then the result register; one beat
// per cycle unless a stalled result holds it, each using at most one ring
// RAM access; a popped byte is the registered RAM read, in the second stage.
// Reset: asynchronous, clears head, tail, line count, arrival flag and the
// pipeline valids; ring contents stay undefined and are never cleared.
`timescale 1ns / 1ps
`default_nettype none

module line_counting_receive_fifo (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       batch_end_i,
  output logic            res_valid_o,
  input  wire logic       res_stall_i,
  output logic      [7:0] out_byte_o,
  output logic            out_valid_o,
  output logic            keep_byte_o,
  output logic            line_end_o,
  output logic      [7:0] lines_pending_o,
  output logic            line_ready_o,
  output logic            data_arrived_o,
  output logic            overflowed_o
);

  import lcrf_pkg::*;

  // architectural state
  idx_t       head_q, head_d;
  idx_t       tail_q, tail_d;
  logic [7:0] lc_q, lc_d;
  logic       arr_q, arr_d;

  // stage 1: RAM read in flight
  logic s1_valid_q;
  logic s1_line_q;
  logic s1_pop_q, s1_pop_d;
  logic s1_lend_empty_q, s1_lend_empty_d;
  logic s1_ovf_q, s1_ovf_d;
  logic s1_arr_q;

  // result register
  logic       res_valid_q;
  logic [7:0] res_byte_q;
  logic       res_pop_q, res_keep_q, res_lend_q, res_ready_q, res_arr_q, res_ovf_q;
  logic [7:0] res_lc_q;

  logic       accept, s1_adv;
  logic       ram_we, ram_re;
  idx_t       next_head, next_tail;
  logic [7:0] rdata;
  logic       byte_end, s1_dec;
  logic [7:0] lc_eff;
  logic       s1_lend, s1_keep;
  cmd_e       cmd;

  assign cmd        = cmd_e'(cmd_i);
  assign s1_adv     = s1_valid_q && (!res_valid_q || !res_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign next_head = next_idx(head_q);
  assign next_tail = next_idx(tail_q);

  lcrf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(next_head),
    .wdata_i(rx_byte_i),
    .re_i   (ram_re),
    .raddr_i(next_tail),
    .rdata_o(rdata)
  );

  // a line pop still in stage 1 may owe the count a decrement
  assign byte_end = (rdata == CH_NL) || (rdata == CH_NUL);
  assign s1_lend  = s1_line_q && ((s1_pop_q && byte_end) || s1_lend_empty_q);
  assign s1_keep  = s1_line_q && s1_pop_q && !byte_end && (rdata != CH_CR);
  assign s1_dec   = s1_valid_q && s1_lend;
  assign lc_eff   = s1_dec ? (lc_q - 8'd1) : lc_q;

  always_comb begin
    head_d          = head_q;
    tail_d          = tail_q;
    lc_d            = lc_eff;
    arr_d           = arr_q;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    s1_pop_d        = 1'b0;
    s1_lend_empty_d = 1'b0;
    s1_ovf_d        = 1'b0;
    if (accept) begin
      case (cmd)
        CMD_PUSH: begin
          if (next_head == tail_q) begin
            // full: drop everything, including this byte
            head_d   = tail_q;
            lc_d     = '0;
            s1_ovf_d = 1'b1;
          end else begin
            ram_we = 1'b1;
            head_d = next_head;
            if (rx_byte_i == CH_NL && lc_eff != LC_MAX) begin
              lc_d = lc_eff + 8'd1;
            end
          end
          if (batch_end_i) begin
            arr_d = 1'b1;
          end
        end
        CMD_POP: begin
          if (head_q == tail_q) begin
            arr_d = 1'b0;
          end else begin
            ram_re   = 1'b1;
            tail_d   = next_tail;
            s1_pop_d = 1'b1;
          end
        end
        CMD_LINE: begin
          if (lc_eff != '0) begin
            if (head_q == tail_q) begin
              arr_d           = 1'b0;
              s1_lend_empty_d = 1'b1;
            end else begin
              ram_re   = 1'b1;
              tail_d   = next_tail;
              s1_pop_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      lc_q        <= '0;
      arr_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      arr_q  <= arr_d;
      if (accept || s1_adv) begin
        lc_q <= lc_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_line_q       <= (cmd == CMD_LINE);
      s1_pop_q        <= s1_pop_d;
      s1_lend_empty_q <= s1_lend_empty_d;
      s1_ovf_q        <= s1_ovf_d;
      s1_arr_q        <= arr_d;
    end
    if (s1_adv) begin
      res_byte_q  <= s1_pop_q ? rdata : 8'h00;
      res_pop_q   <= s1_pop_q;
      res_keep_q  <= s1_keep;
      res_lend_q  <= s1_lend;
      res_lc_q    <= lc_eff;
      res_ready_q <= (lc_eff != '0);
      res_arr_q   <= s1_arr_q;
      res_ovf_q   <= s1_ovf_q;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign out_byte_o      = res_byte_q;
  assign out_valid_o     = res_pop_q;
  assign keep_byte_o     = res_keep_q;
  assign line_end_o      = res_lend_q;
  assign lines_pending_o = res_lc_q;
  assign line_ready_o    = res_ready_q;
  assign data_arrived_o  = res_arr_q;
  assign overflowed_o    = res_ovf_q;

`include "line_counting_receive_fifo_macros.svh"

  `LCRF_ASSERT_NOW(a_lend_not_kept, res_valid_o && line_end_o, !keep_byte_o, "line end byte marked kept")
  `LCRF_ASSERT_NOW(a_ovf_clears, res_valid_o && overflowed_o, !out_valid_o && lines_pending_o == 8'd0, "overflow beat with count or data")
  `LCRF_ASSERT_NXT(a_stall_holds_idx, in_stall_o, $stable(head_q) && $stable(tail_q), "indices moved while stalled")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Testbench for the line-counting receive FIFO: directed and random beats against a scoreboard
`timescale 1ns / 1ps

module testbench;
  import lcrf_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       keep_byte;
    logic       line_end;
    logic [7:0] lines_pending;
    logic       line_ready;
    logic       data_arrived;
    logic       overflowed;
  } result_t;

  // Tracks ring contents, indexes, line count and arrival flag; queues the result of every beat
  class line_fifo_scoreboard;
    logic [7:0] ring [DEPTH];
    idx_t       head;
    idx_t       tail;
    logic [7:0] lines;
    logic       arrived;
    result_t    last;
    result_t    awaited_results [$];
    int         errors;
    int         n_checked;
    int         n_push;
    int         n_popped;
    int         n_line_end;
    int         n_overflow;
    int         n_saturated;
    int         n_noop;

    function new();
      head    = '0;
      tail    = '0;
      lines   = '0;
      arrived = 1'b0;
      last    = '0;
    endfunction

    function idx_t step_idx(idx_t i);
      return idx_t'((int'(i) + 1) % DEPTH);
    endfunction

    function bit is_empty();
      return head == tail;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void note_beat(cmd_e cmd, logic [7:0] rx, logic be);
      result_t    r;
      idx_t       nh;
      logic [7:0] b;
      r = '0;
      case (cmd)
        CMD_PUSH: begin
          n_push++;
          nh = step_idx(head);
          if (nh == tail) begin
            // full: drop the byte and throw away everything stored
            head = tail;
            lines = '0;
            r.overflowed = 1'b1;
            n_overflow++;
          end else begin
            ring[nh] = rx;
            if (rx == CH_NL) begin
              if (lines == LC_MAX) n_saturated++;
              else lines++;
            end
            head = nh;
          end
          if (be) arrived = 1'b1;
        end
        CMD_POP: begin
          if (head == tail) begin
            arrived = 1'b0;
          end else begin
            tail = step_idx(tail);
            r.out_byte = ring[tail];
            r.out_valid = 1'b1;
            n_popped++;
          end
        end
        CMD_LINE: begin
          if (lines != '0) begin
            if (head == tail) begin
              // pending line but nothing stored: the line is taken as ended
              arrived = 1'b0;
              r.line_end = 1'b1;
            end else begin
              tail = step_idx(tail);
              b = ring[tail];
              r.out_byte = b;
              r.out_valid = 1'b1;
              n_popped++;
              if (b == CH_NL || b == CH_NUL) r.line_end = 1'b1;
              else if (b != CH_CR) r.keep_byte = 1'b1;
            end
            if (r.line_end) begin
              lines--;
              n_line_end++;
            end
          end
        end
        default: n_noop++;
      endcase
      r.lines_pending = lines;
      r.line_ready = (lines != '0);
      r.data_arrived = arrived;
      last = r;
      awaited_results.push_back(r);
    endfunction

    function void field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: out_byte %0h", got.out_byte);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      n_checked++;
      field("out_byte", want.out_byte, got.out_byte);
      field("out_valid", want.out_valid, got.out_valid);
      field("keep_byte", want.keep_byte, got.keep_byte);
      field("line_end", want.line_end, got.line_end);
      field("lines_pending", want.lines_pending, got.lines_pending);
      field("line_ready", want.line_ready, got.line_ready);
      field("data_arrived", want.data_arrived, got.data_arrived);
      field("overflowed", want.overflowed, got.overflowed);
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] cmd_i       = CMD_NOP;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       batch_end_i = 1'b0;
  logic       res_stall_i = 1'b0;
  logic       in_stall_o;
  logic       res_valid_o;
  logic [7:0] out_byte_o;
  logic       out_valid_o;
  logic       keep_byte_o;
  logic       line_end_o;
  logic [7:0] lines_pending_o;
  logic       line_ready_o;
  logic       data_arrived_o;
  logic       overflowed_o;

  line_fifo_scoreboard sb = new();
  result_t got_beat;
  int send_idle_pct = 17;
  int stall_pct     = 17;
  int holdoff_req   = 0;
  int beats_sent    = 0;

  line_counting_receive_fifo uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .rx_byte_i      (rx_byte_i),
    .batch_end_i    (batch_end_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .out_byte_o     (out_byte_o),
    .out_valid_o    (out_valid_o),
    .keep_byte_o    (keep_byte_o),
    .line_end_o     (line_end_o),
    .lines_pending_o(lines_pending_o),
    .line_ready_o   (line_ready_o),
    .data_arrived_o (data_arrived_o),
    .overflowed_o   (overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #1ms;
    $display("testbench NOT OK");
    $finish;
  end

  // result side: random stalls, plus a hold-off counted down here
  always @(posedge clk_i) begin
    if (holdoff_req > 0) begin
      res_stall_i <= 1'b1;
      holdoff_req--;
    end else begin
      res_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // everything settles between edges, so the negedge sees what the next edge accepts
  always @(negedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1 && res_stall_i == 1'b0) begin
      got_beat = {out_byte_o, out_valid_o, keep_byte_o, line_end_o, lines_pending_o,
                  line_ready_o, data_arrived_o, overflowed_o};
      sb.check_beat(got_beat);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // mostly printable text, now and then any byte at all
  function automatic logic [7:0] text_byte();
    if ($urandom_range(7) == 0) return rand_byte();
    return 8'($urandom_range(8'h7E, 8'h20));
  endfunction

  // called at a rising edge; returns at the edge that took the beat
  task automatic send_beat(cmd_e c, logic [7:0] b, logic be);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    rx_byte_i   <= b;
    batch_end_i <= be;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      if (took) sb.note_beat(c, b, be);
      @(posedge clk_i);
    end while (!took);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic push_line(int len, bit with_cr);
    repeat (len) send_beat(CMD_PUSH, text_byte(), 1'b0);
    if (with_cr) send_beat(CMD_PUSH, CH_CR, 1'b0);
    send_beat(CMD_PUSH, CH_NL, 1'b1);
  endtask

  // pops line bytes until the predicted line ends or nothing comes out
  task automatic read_line();
    int guard;
    guard = 0;
    do begin
      send_beat(CMD_LINE, rand_byte(), 1'($urandom_range(1)));
      guard++;
    end while (!sb.last.line_end && sb.last.out_valid && guard < 300);
  endtask

  task automatic random_mix(int beats);
    int stop;
    int pick;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        push_line($urandom_range(12), 1'($urandom_range(1)));
      end else if (pick < 70) begin
        read_line();
      end else if (pick < 80) begin
        repeat ($urandom_range(5, 1)) send_beat(CMD_POP, rand_byte(), 1'($urandom_range(1)));
      end else if (pick < 90) begin
        repeat ($urandom_range(6, 1))
          send_beat(cmd_e'($urandom_range(3)), rand_byte(), 1'($urandom_range(1)));
      end else if (pick < 95) begin
        // partial line, no newline yet
        repeat ($urandom_range(6, 1)) send_beat(CMD_PUSH, text_byte(), 1'b0);
        send_beat(CMD_PUSH, text_byte(), 1'b1);
      end else begin
        // line cut short by a NUL
        repeat ($urandom_range(4)) send_beat(CMD_PUSH, text_byte(), 1'b0);
        send_beat(CMD_PUSH, CH_NUL, 1'b0);
        push_line($urandom_range(3), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(CMD_POP,  8'h00, 1'b1);
    send_beat(CMD_LINE, 8'hFF, 1'b0);
    send_beat(CMD_NOP,  8'hFF, 1'b1);
    send_beat(CMD_PUSH, 8'hFF, 1'b0);
    send_beat(CMD_PUSH, CH_NUL, 1'b0);
    send_beat(CMD_PUSH, CH_CR, 1'b0);
    send_beat(CMD_PUSH, CH_NL, 1'b1);
    send_beat(CMD_LINE, 8'h00, 1'b0);
    send_beat(CMD_LINE, 8'h00, 1'b0);
    send_beat(CMD_LINE, 8'h00, 1'b0);
    send_beat(CMD_POP,  8'h00, 1'b0);
    send_beat(CMD_POP,  8'h00, 1'b0);
    send_beat(CMD_POP,  8'h00, 1'b0);
    send_beat(CMD_PUSH, 8'h41, 1'b0);
    send_beat(CMD_PUSH, CH_NL, 1'b1);
    send_beat(CMD_POP,  8'h00, 1'b0);
    send_beat(CMD_POP,  8'h00, 1'b0);
    // count says a line is there but the buffer is empty
    send_beat(CMD_LINE, 8'h00, 1'b0);
    send_beat(CMD_PUSH, 8'h55, 1'b0);
    send_beat(CMD_PUSH, 8'hAA, 1'b1);
    send_beat(CMD_LINE, 8'h00, 1'b1);
    send_beat(CMD_POP,  8'h00, 1'b0);
    send_beat(CMD_POP,  8'h00, 1'b0);
    send_beat(CMD_NOP,  8'h00, 1'b0);

    // back-to-back stretch, no idling on either side
    send_idle_pct = 0;
    stall_pct = 0;
    random_mix(150);
    send_idle_pct = 17;
    stall_pct = 17;
    random_mix(100);

    // long hold-off on results while beats keep coming
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    holdoff_req = 60;
    @(posedge clk_i);
    random_mix(30);
    wait_drained();

    // newline flood: fill with newlines, push past the count limit, then overflow
    while (!sb.is_empty()) send_beat(CMD_POP, rand_byte(), 1'b0);
    repeat (DEPTH - 1) send_beat(CMD_PUSH, CH_NL, 1'b0);
    repeat (3) send_beat(CMD_POP, rand_byte(), 1'b0);
    repeat (3) send_beat(CMD_PUSH, CH_NL, 1'b0);
    send_beat(CMD_PUSH, 8'h5A, 1'b1);
    repeat (4) send_beat(CMD_LINE, rand_byte(), 1'b0);
    wait_drained();

    // fill with random bytes until the buffer overflows
    do send_beat(CMD_PUSH, rand_byte(), 1'($urandom_range(1)));
    while (!sb.last.overflowed);
    random_mix(100);

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d result beats: %0d pushes, %0d bytes popped, %0d overflows",
             sb.n_checked, sb.n_push, sb.n_popped, sb.n_overflow);
    $display("%0d line ends, %0d newlines at the count limit, %0d no-op beats",
             sb.n_line_end, sb.n_saturated, sb.n_noop);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
